[rtl/hff_pkg.sv]
// Shared types, constants and helpers for the hex field formatter.
package hff_pkg;

    localparam int VALUE_W  = 32;
    localparam int NIB_W    = 4;
    localparam int NIBBLES  = VALUE_W / NIB_W;
    localparam int CNT_W    = 7;
    localparam int DIG_W    = 4;
    localparam int CHAR_W   = 8;

    localparam logic [CNT_W-1:0]  MAX_CHARS = 7'd64;
    localparam logic [5:0]        MAX_PREC  = 6'd62;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;

    // remaining length of each part of the field
    typedef struct packed {
        logic [CNT_W-1:0] lead;
        logic             pfx;
        logic [CNT_W-1:0] zeros;
        logic [DIG_W-1:0] digs;
        logic [CNT_W-1:0] trail;
    } plan_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LEAD  = 7'b0000010,
        ST_PFX0  = 7'b0000100,
        ST_PFXX  = 7'b0001000,
        ST_ZERO  = 7'b0010000,
        ST_DIGIT = 7'b0100000,
        ST_TRAIL = 7'b1000000
    } state_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
        logic [CHAR_W-1:0] c;
        begin
            if (nib < 4'd10)
                c = CHAR_ZERO + CHAR_W'(nib);
            else
                c = 8'h61 + CHAR_W'(nib - 4'd10);
            return c;
        end
    endfunction

    // first non-empty part that follows part s; ST_IDLE as s means "from the start"
    function automatic state_t seg_after(input state_t s, input plan_t p);
        logic from_lead;
        logic from_pfx;
        logic from_zero;
        logic from_dig;
        logic from_trail;
        state_t nxt;
        begin
            from_lead  = (s == ST_IDLE);
            from_pfx   = from_lead | (s == ST_LEAD);
            from_zero  = from_pfx  | (s == ST_PFXX);
            from_dig   = from_zero | (s == ST_ZERO);
            from_trail = from_dig  | (s == ST_DIGIT);
            priority if (from_lead && p.lead != '0)
                nxt = ST_LEAD;
            else if (from_pfx && p.pfx)
                nxt = ST_PFX0;
            else if (from_zero && p.zeros != '0)
                nxt = ST_ZERO;
            else if (from_dig && p.digs != '0)
                nxt = ST_DIGIT;
            else if (from_trail && p.trail != '0)
                nxt = ST_TRAIL;
            else
                nxt = ST_IDLE;
            return nxt;
        end
    endfunction

endpackage

[rtl/hff_plan.sv]
// Works out the length of each part of the field from one input word.
module hff_plan (
    input  logic [hff_pkg::VALUE_W-1:0] value,
    input  logic [6:0]                  field_width,
    input  logic signed [6:0]           digit_precision,
    input  logic                        left_justify,
    input  logic                        zero_pad,
    input  logic                        with_prefix,
    output hff_pkg::plan_t              plan
);
    import hff_pkg::*;

    logic             prec_given;
    logic [CNT_W-1:0] prec;
    logic [DIG_W-1:0] nz_cnt;
    logic [DIG_W-1:0] ndig;
    logic             val_zero;
    logic [CNT_W-1:0] wid;
    logic             pfx;
    logic [CNT_W-1:0] pw;
    logic [CNT_W-1:0] ndigits;
    logic [CNT_W-1:0] body;
    logic [CNT_W-1:0] pad;

    always_comb
    begin
        prec_given = !digit_precision[6];
        prec = (digit_precision[5:0] > MAX_PREC) ? CNT_W'(MAX_PREC)
                                                 : CNT_W'(digit_precision[5:0]);

        // count of significant nibbles
        nz_cnt = '0;
        for (int i = 0; i < NIBBLES; i++)
        begin
            if (value[i*NIB_W +: NIB_W] != '0)
                nz_cnt = DIG_W'(i + 1);
        end

        val_zero = (value == '0);
        if (val_zero)
            ndig = (prec_given && prec == '0) ? DIG_W'(0) : DIG_W'(1);
        else
            ndig = nz_cnt;

        wid = (field_width > MAX_CHARS) ? MAX_CHARS : field_width;
        pfx = with_prefix && !val_zero;
        pw  = pfx ? CNT_W'(2) : CNT_W'(0);

        ndigits = CNT_W'(ndig);
        if (prec_given && prec > ndigits)
            ndigits = prec;
        body = pw + ndigits;

        if (zero_pad && !left_justify && !prec_given && wid > body)
        begin
            ndigits = wid - pw;
            body    = wid;
        end

        pad = (wid > body) ? (wid - body) : '0;

        plan.lead  = left_justify ? '0 : pad;
        plan.trail = left_justify ? pad : '0;
        plan.pfx   = pfx;
        plan.zeros = ndigits - CNT_W'(ndig);
        plan.digs  = ndig;
    end

endmodule

[rtl/hff_nibble_sr.sv]
// Nibble shift register: aligns the top significant digit and shifts one digit out per step.
module hff_nibble_sr (
    input  logic                          clk,
    input  logic                          load,
    input  logic [hff_pkg::VALUE_W-1:0]   value,
    input  logic [hff_pkg::DIG_W-1:0]     ndig,
    input  logic                          shift,
    output logic [hff_pkg::CHAR_W-1:0]    digit_char
);
    import hff_pkg::*;

    logic [VALUE_W-1:0] sr_reg;
    logic [2:0]         skip;

    // leading zero nibbles to drop; ndig of zero never reaches the digit phase
    assign skip = 3'(4'd8 - ndig);

    always_ff @(posedge clk)
    begin
        if (load)
            sr_reg <= value << {skip, 2'b00};
        else if (shift)
            sr_reg <= {sr_reg[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
    end

    assign digit_char = hex_char(sr_reg[VALUE_W-1 -: NIB_W]);

endmodule

[rtl/hex_field_formatter_unit.sv]
// Top level of the hex field formatter: sequencer, digit shifter and output register.
//
// Formats a 32-bit value as lower-case hex text by printf %x rules (width,
// precision, '-', '0', '#') and sends it one ASCII character per output word,
// with last_char set on the final one. An item is first loaded and then sends its
// characters, up to 64; the character sequencer emits at most one
// character per cycle and a new item is taken once the previous item's last
// character has entered the output register. Value 0 with precision 0 and width
// 0 yields no characters. No clearing pass or setup is needed after reset.
module hex_field_formatter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [hff_pkg::VALUE_W-1:0] value,
    input  logic [6:0]                  field_width,
    input  logic signed [6:0]           digit_precision,
    input  logic                        left_justify,
    input  logic                        zero_pad,
    input  logic                        with_prefix,
    output logic                        char_valid,
    input  logic                        char_stall,
    output logic [hff_pkg::CHAR_W-1:0]  out_char,
    output logic                        last_char
);
    import hff_pkg::*;

    plan_t             plan_in;
    plan_t             plan_reg;
    plan_t             plan_next;
    state_t            state_reg;
    state_t            state_next;
    state_t            after_seg;
    logic              accept;
    logic              emit;
    logic              seg_done;
    logic              cur_last;
    logic [CHAR_W-1:0] cur_char;
    logic [CHAR_W-1:0] digit_char;
    logic              char_valid_reg;
    logic              char_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic              last_char_reg;

    hff_plan u_plan (
        .value           (value),
        .field_width     (field_width),
        .digit_precision (digit_precision),
        .left_justify    (left_justify),
        .zero_pad        (zero_pad),
        .with_prefix     (with_prefix),
        .plan            (plan_in)
    );

    hff_nibble_sr u_sr (
        .clk        (clk),
        .load       (accept),
        .value      (value),
        .ndig       (plan_in.digs),
        .shift      (emit && state_reg == ST_DIGIT),
        .digit_char (digit_char)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign emit       = (state_reg != ST_IDLE) && (!char_valid_reg || !char_stall);

    always_comb
    begin
        plan_next = plan_reg;
        cur_char  = CHAR_SPACE;
        seg_done  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cur_char = CHAR_SPACE;
            end
            ST_LEAD:
            begin
                cur_char       = CHAR_SPACE;
                seg_done       = (plan_reg.lead == CNT_W'(1));
                plan_next.lead = plan_reg.lead - CNT_W'(1);
            end
            ST_PFX0:
            begin
                cur_char = CHAR_ZERO;
            end
            ST_PFXX:
            begin
                cur_char = CHAR_X;
                seg_done = 1'b1;
            end
            ST_ZERO:
            begin
                cur_char        = CHAR_ZERO;
                seg_done        = (plan_reg.zeros == CNT_W'(1));
                plan_next.zeros = plan_reg.zeros - CNT_W'(1);
            end
            ST_DIGIT:
            begin
                cur_char       = digit_char;
                seg_done       = (plan_reg.digs == DIG_W'(1));
                plan_next.digs = plan_reg.digs - DIG_W'(1);
            end
            ST_TRAIL:
            begin
                cur_char        = CHAR_SPACE;
                seg_done        = (plan_reg.trail == CNT_W'(1));
                plan_next.trail = plan_reg.trail - CNT_W'(1);
            end
            default:
            begin
                cur_char = CHAR_SPACE;
            end
        endcase

        after_seg = seg_after(state_reg, plan_reg);
        cur_last  = seg_done && (after_seg == ST_IDLE);

        state_next = state_reg;
        if (accept)
        begin
            state_next = seg_after(ST_IDLE, plan_in);
            plan_next  = plan_in;
        end
        else if (emit)
        begin
            if (state_reg == ST_PFX0)
                state_next = ST_PFXX;
            else if (seg_done)
                state_next = after_seg;
        end
        else
        begin
            plan_next = plan_reg;
        end

        char_valid_next = char_valid_reg;
        if (emit)
            char_valid_next = 1'b1;
        else if (char_valid_reg && !char_stall)
            char_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
        if (emit)
        begin
            out_char_reg  <= cur_char;
            last_char_reg <= cur_last;
        end
    end

    assign char_valid = char_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_char_reg;

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cur_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer still busy after last character");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (plan_reg.digs != '0))
        else $error("digit phase with no digits left");

    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZERO) |-> (plan_reg.zeros != '0))
        else $error("zero fill phase with no zeros left");

    a_prefix_order: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_PFXX) |-> $past(state_reg == ST_PFX0))
        else $error("prefix x without leading 0");

endmodule

[tb/sv/hex_field_formatter_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for hex_field_formatter_unit: printf %x text checked word by word.
module hex_field_formatter_unit_tb;

    localparam int CLK_HALF   = 4;
    localparam int RAND_ITEMS = 350;
    localparam int TAIL_WAIT  = 100;
    localparam int MAX_CYCLES = 2000000;
    localparam int FIELD_MAX  = 64;
    localparam int PREC_MAX   = 62;

    typedef struct {
        logic [hff_pkg::VALUE_W-1:0] num;
        logic [6:0]                  width;
        logic signed [6:0]           prec;
        logic                        lj;
        logic                        zp;
        logic                        pf;
    } fmt_item_t;

    typedef struct {
        logic [hff_pkg::CHAR_W-1:0] ch;
        logic                       fin;
    } char_word_t;

    // expected text of every accepted item, one entry per output word
    class hex_text_board;
        char_word_t due_q[$];
        int         errors;
        int         words_seen;

        function new();
            errors = 0;
            words_seen = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // printf %x: lead spaces, 0x, pad zeros, digits, trail spaces
        function void note_item(fmt_item_t it);
            string                       hex_set;
            logic [hff_pkg::VALUE_W-1:0] t;
            int                          w;
            int                          p;
            int                          nd;
            int                          total_dig;
            int                          pfx;
            int                          lead;
            int                          trail;
            int                          k;
            logic [hff_pkg::CHAR_W-1:0]  text[$];
            char_word_t                  cw;
            hex_set = "0123456789abcdef";
            w = int'(it.width);
            if (w > FIELD_MAX)
                w = FIELD_MAX;
            p = (it.prec < 0) ? -1 : int'(it.prec);
            if (p > PREC_MAX)
                p = PREC_MAX;
            nd = 0;
            t = it.num;
            while (t != 0)
            begin
                nd++;
                t = t >> 4;
            end
            if (it.num == 0 && p != 0)
                nd = 1;
            pfx = (it.pf && it.num != 0) ? 2 : 0;
            total_dig = (p > nd) ? p : nd;
            // zero fill only when no precision and right-justified
            if (it.zp && !it.lj && p < 0 && w > pfx + total_dig)
                total_dig = w - pfx;
            lead = 0;
            trail = 0;
            if (w > pfx + total_dig)
            begin
                if (it.lj)
                    trail = w - pfx - total_dig;
                else
                    lead = w - pfx - total_dig;
            end
            for (k = 0; k < lead; k++)
                text.push_back(hff_pkg::CHAR_SPACE);
            if (pfx != 0)
            begin
                text.push_back(hff_pkg::CHAR_ZERO);
                text.push_back(hff_pkg::CHAR_X);
            end
            for (k = 0; k < total_dig - nd; k++)
                text.push_back(hff_pkg::CHAR_ZERO);
            for (k = nd - 1; k >= 0; k--)
                text.push_back(hex_set[int'(it.num[4*k +: 4])]);
            for (k = 0; k < trail; k++)
                text.push_back(hff_pkg::CHAR_SPACE);
            for (k = 0; k < text.size() && k < FIELD_MAX; k++)
            begin
                cw.ch = text[k];
                cw.fin = (k == text.size() - 1) || (k == FIELD_MAX - 1);
                due_q.push_back(cw);
            end
        endfunction

        task check_char(logic [hff_pkg::CHAR_W-1:0] ch, logic fin);
            char_word_t want;
            words_seen++;
            if (due_q.size() == 0)
            begin
                report($sformatf("word %0d: unexpected char %h last %b", words_seen, ch, fin));
                return;
            end
            want = due_q.pop_front();
            if (ch !== want.ch)
                report($sformatf("word %0d: out_char %h, want %h", words_seen, ch, want.ch));
            if (fin !== want.fin)
                report($sformatf("word %0d: last_char %b, want %b", words_seen, fin, want.fin));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_stall;
    logic [hff_pkg::VALUE_W-1:0] value;
    logic [6:0]                  field_width;
    logic signed [6:0]           digit_precision;
    logic                        left_justify;
    logic                        zero_pad;
    logic                        with_prefix;
    logic                        char_valid;
    logic                        char_stall;
    logic [hff_pkg::CHAR_W-1:0]  out_char;
    logic                        last_char;

    hex_text_board board;
    logic          calm;
    int            cycles = 0;

    hex_field_formatter_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .value           (value),
        .field_width     (field_width),
        .digit_precision (digit_precision),
        .left_justify    (left_justify),
        .zero_pad        (zero_pad),
        .with_prefix     (with_prefix),
        .char_valid      (char_valid),
        .char_stall      (char_stall),
        .out_char        (out_char),
        .last_char       (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES)
        begin
            $display("hex_field_formatter_unit_tb: errors");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (calm)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1, 2:    return $urandom_range(0, 3);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic fmt_item_t mk(logic [31:0] n, int w, int p, int lj, int zp, int pf);
        fmt_item_t it;
        it.num   = n;
        it.width = w[6:0];
        it.prec  = p[6:0];
        it.lj    = lj[0];
        it.zp    = zp[0];
        it.pf    = pf[0];
        return it;
    endfunction

    function automatic fmt_item_t rand_item();
        fmt_item_t it;
        case ($urandom_range(0, 4))
            0:       it.num = '0;
            1:       it.num = $urandom_range(0, 15);
            2:       it.num = $urandom >> $urandom_range(0, 31);
            default: it.num = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       it.width = 7'($urandom_range(0, 127));
            1:       it.width = 7'($urandom_range(0, 64));
            default: it.width = 7'($urandom_range(0, 16));
        endcase
        case ($urandom_range(0, 5))
            0, 1:    it.prec = -7'sd1;
            2:       it.prec = 7'($urandom_range(64, 127));  // any negative
            3:       it.prec = 7'($urandom_range(0, 63));
            default: it.prec = 7'($urandom_range(0, 12));
        endcase
        it.lj = 1'($urandom_range(0, 1));
        it.zp = 1'($urandom_range(0, 1));
        it.pf = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // valid stays high across back-to-back words; low only during a drawn gap
    task automatic send_item(fmt_item_t it);
        int   gap;
        logic s;
        gap = draw_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid      <= 1'b1;
        value           <= it.num;
        field_width     <= it.width;
        digit_precision <= it.prec;
        left_justify    <= it.lj;
        zero_pad        <= it.zp;
        with_prefix     <= it.pf;
        forever
        begin
            @(negedge clk);
            s = item_stall;
            @(posedge clk);
            if (s === 1'b0)
                break;
        end
        board.note_item(it);
    endtask

    task automatic drain_chars();
        int                         hold;
        logic                       v;
        logic [hff_pkg::CHAR_W-1:0] c;
        logic                       l;
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                char_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                char_stall <= 1'b0;
            end
            forever
            begin
                @(negedge clk);
                v = char_valid;
                c = out_char;
                l = last_char;
                @(posedge clk);
                if (v === 1'b1)
                    break;
            end
            board.check_char(c, l);
        end
    endtask

    initial
    begin
        int i;
        board = new();
        calm  = 1'b0;
        rst_n           <= 1'b0;
        item_valid      <= 1'b0;
        value           <= '0;
        field_width     <= '0;
        digit_precision <= '0;
        left_justify    <= 1'b0;
        zero_pad        <= 1'b0;
        with_prefix     <= 1'b0;
        char_stall      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            drain_chars();
        join_none

        // directed corners
        send_item(mk(32'h0, 0, 0, 0, 0, 0));            // empty field
        send_item(mk(32'h0, 0, 0, 0, 1, 1));            // empty field, flags ignored
        send_item(mk(32'h0, 0, -1, 0, 0, 0));           // plain zero
        send_item(mk(32'h0, 6, -1, 0, 1, 1));           // zero: no prefix, zero fill
        send_item(mk(32'hffffffff, 0, -1, 0, 0, 1));
        send_item(mk(32'hdeadbeef, 64, -1, 1, 0, 1));
        send_item(mk(32'h1a, 10, -1, 0, 1, 1));          // 0x then zero fill
        send_item(mk(32'h1a, 10, 3, 0, 1, 1));           // precision kills zero fill
        send_item(mk(32'h1a, 10, -1, 1, 1, 0));          // left-justify kills zero fill
        send_item(mk(32'h1, 20, 8, 0, 0, 1));
        send_item(mk(32'h80000000, 0, 62, 0, 0, 1));     // 64 characters
        send_item(mk(32'h12345678, 0, 63, 1, 0, 1));     // precision clamps to 62
        send_item(mk(32'habc, 127, -1, 0, 0, 0));        // width clamps to 64
        send_item(mk(32'habc, 65, -1, 1, 0, 1));
        send_item(mk(32'habc, 100, -1, 0, 1, 1));
        send_item(mk(32'h5, 4, -64, 0, 1, 0));           // most negative precision
        send_item(mk(32'h0, 5, 0, 0, 0, 1));             // spaces only
        send_item(mk(32'h0, 3, 0, 1, 1, 0));
        send_item(mk(32'h0, 0, 62, 0, 0, 1));
        send_item(mk(32'hf, 1, 1, 0, 0, 0));
        send_item(mk(32'h7fffffff, 127, 63, 0, 1, 1));
        send_item(mk(32'h0, 64, -1, 0, 1, 0));
        send_item(mk(32'h10, 2, -1, 0, 1, 1));           // width below content

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_item(rand_item());
        end
        item_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("hex_field_formatter_unit_tb: clean");
        else
            $display("hex_field_formatter_unit_tb: errors");
        $finish;
    end

endmodule
